### rtl/lcgm_pkg.sv
// ----------------------------------------------------------------------------
// LOCO context Golomb modeler package
// Shared constants and types for the context modeler and its context store.
// ----------------------------------------------------------------------------
`default_nettype none

package lcgm_pkg;

  localparam int PixW         = 8;
  localparam int QuantW       = 3;
  localparam int CtxAw        = 10;
  localparam int CtxDepth     = 1 << CtxAw;
  localparam int SumW         = 16;
  localparam int CountW       = 8;
  localparam int KW           = 5;
  localparam int MapW         = 9;
  localparam int UnaryW       = 10;
  localparam int ActW         = 10;
  localparam int TexW         = 3;
  localparam int ShiftW       = CountW + 16;

  localparam int MaxQuantBits = 7;
  localparam int CountLimit   = 128;
  localparam int KLimit       = 16;
  localparam int ActBits      = 10;
  localparam int SumReset     = 8;
  localparam int CountReset   = 1;
  localparam int QuantReset   = 2;

  typedef struct packed {
    logic [SumW-1:0]   sum;
    logic [CountW-1:0] count;
  } ctx_entry_t;

  typedef struct packed {
    logic             rd;
    logic             wr;
    logic [CtxAw-1:0] addr;
    ctx_entry_t       wdata;
  } ctx_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PRED,
    ST_ACT,
    ST_READ,
    ST_LOAD,
    ST_SEARCH,
    ST_UPDATE
  } state_e;

endpackage

`default_nettype wire

### rtl/lcgm_in_if.sv
// ----------------------------------------------------------------------------
// LOCO context Golomb modeler pixel channel
// Valid/ready channel carrying the pixel and its three causal neighbours.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcgm_in_if;
  logic                     valid;
  logic                     ready;
  logic [lcgm_pkg::PixW-1:0] pixel_value;
  logic [lcgm_pkg::PixW-1:0] left_neighbor;
  logic [lcgm_pkg::PixW-1:0] upper_neighbor;
  logic [lcgm_pkg::PixW-1:0] corner_neighbor;

  modport source (
    output valid, pixel_value, left_neighbor, upper_neighbor, corner_neighbor,
    input  ready
  );

  modport sink (
    input  valid, pixel_value, left_neighbor, upper_neighbor, corner_neighbor,
    output ready
  );
endinterface

`default_nettype wire

### rtl/lcgm_out_if.sv
// ----------------------------------------------------------------------------
// LOCO context Golomb modeler result channel
// Valid/ready channel carrying prediction, context and Golomb code fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcgm_out_if;
  logic                        valid;
  logic                        ready;
  logic [lcgm_pkg::PixW-1:0]   prediction;
  logic [lcgm_pkg::CtxAw-1:0]  context_index;
  logic [lcgm_pkg::KW-1:0]     rice_k;
  logic [lcgm_pkg::MapW-1:0]   mapped_error;
  logic [lcgm_pkg::MapW-1:0]   binary_part;
  logic [lcgm_pkg::UnaryW-1:0] unary_length;

  modport source (
    output valid, prediction, context_index, rice_k, mapped_error, binary_part,
           unary_length,
    input  ready
  );

  modport sink (
    input  valid, prediction, context_index, rice_k, mapped_error, binary_part,
           unary_length,
    output ready
  );
endinterface

`default_nettype wire

### rtl/lcgm_ctx_store.sv
// ----------------------------------------------------------------------------
// LOCO context store
// Single-port context memory of error sums and hit counts, with a clearing
// sweep after reset that loads every entry with its initial value.
// ----------------------------------------------------------------------------
`default_nettype none

module lcgm_ctx_store (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  lcgm_pkg::ctx_req_t    req_i,
  output lcgm_pkg::ctx_entry_t  rdata_o,
  output logic                  busy_o
);

  lcgm_pkg::ctx_entry_t mem [lcgm_pkg::CtxDepth];
  lcgm_pkg::ctx_entry_t rdata_q;

  logic                       busy_q, busy_d;
  logic [lcgm_pkg::CtxAw-1:0] clr_addr_q, clr_addr_d;

  logic                       wr_en;
  logic [lcgm_pkg::CtxAw-1:0] wr_addr;
  lcgm_pkg::ctx_entry_t       wr_data;

  always_comb begin
    busy_d     = busy_q;
    clr_addr_d = clr_addr_q;
    if (busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (&clr_addr_q) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      busy_q     <= busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // sweep the initial value through while clearing, else take the request
  always_comb begin
    wr_en   = busy_q | req_i.wr;
    wr_addr = busy_q ? clr_addr_q : req_i.addr;
    wr_data = req_i.wdata;
    if (busy_q) begin
      wr_data.sum   = lcgm_pkg::SumW'(lcgm_pkg::SumReset);
      wr_data.count = lcgm_pkg::CountW'(lcgm_pkg::CountReset);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

`default_nettype wire

### rtl/loco_context_golomb_modeler_core.sv
// ----------------------------------------------------------------------------
// LOCO context Golomb modeler core
// Per-pixel median prediction, context selection, Golomb k choice, error
// mapping and context update of a LOCO-style lossless coder.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : pixel x with neighbours a (left), b (upper), c (corner).
//   out_if : prediction, context index, k, mapped error, binary part and
//            unary length, one transaction for every pixel transaction.
//   cfg    : cfg_we_i writes cfg_wdata_i into the quantiser bit count.
// Timing: after reset the context store is swept once through every entry,
//   during which in_if.ready stays low. A pixel is then accepted only in the
//   idle state, after the previous pixel has written its context back; k
//   (0..16) is the Golomb parameter found, the k search steps one
//   shift-and-compare per cycle on a single comparator, and the context read
//   and write share one port. The result is written to an output register.
//   The next pixel is taken while a result waits; if the receiver stalls,
//   the following pixel holds in its update step until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module loco_context_golomb_modeler_core (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [lcgm_pkg::QuantW-1:0]    cfg_wdata_i,
  lcgm_in_if.sink                       in_if,
  lcgm_out_if.source                    out_if
);

  localparam int PixW   = lcgm_pkg::PixW;
  localparam int SumW   = lcgm_pkg::SumW;
  localparam int CountW = lcgm_pkg::CountW;
  localparam int ShiftW = lcgm_pkg::ShiftW;
  localparam int MapW   = lcgm_pkg::MapW;

  lcgm_pkg::state_e state_q, state_d;

  logic [lcgm_pkg::QuantW-1:0] quant_q;

  logic [PixW-1:0] x_q, a_q, b_q, c_q;
  logic [PixW-1:0] p_q;
  logic [PixW-1:0] mag_q;
  logic            neg_q;
  logic [lcgm_pkg::CtxAw-1:0] idx_q;
  logic [SumW-1:0]   sum_q;
  logic [CountW-1:0] count_q;
  logic [ShiftW-1:0] shift_q;
  logic [lcgm_pkg::KW-1:0] k_q;

  logic                         out_valid_q;
  logic [PixW-1:0]              out_pred_q;
  logic [lcgm_pkg::CtxAw-1:0]   out_idx_q;
  logic [lcgm_pkg::KW-1:0]      out_k_q;
  logic [MapW-1:0]              out_map_q;
  logic [MapW-1:0]              out_bin_q;
  logic [lcgm_pkg::UnaryW-1:0]  out_una_q;

  lcgm_pkg::ctx_req_t   ctx_req;
  lcgm_pkg::ctx_entry_t ctx_rdata;
  logic                 ctx_busy;

  logic in_fire, out_fire, out_free;
  logic search_done, do_update;

  // median edge prediction
  logic [PixW-1:0] med_hi, med_lo, med_p;
  logic [PixW:0]   med_grad;

  // activity and context index
  logic [PixW-1:0] ad_a, ad_b, ad_c;
  logic [lcgm_pkg::ActW-1:0] act, act_q;
  logic [3:0] s_clamp, act_sh;
  logic [lcgm_pkg::TexW-1:0] tex;
  logic [lcgm_pkg::CtxAw-1:0] idx_next;

  // error mapping and context update
  logic [MapW-1:0]   mapped;
  logic [SumW-1:0]   upd_sum_base;
  logic [CountW-1:0] upd_cnt_base;
  logic [SumW:0]     upd_sum_wide;
  lcgm_pkg::ctx_entry_t upd_entry;

  lcgm_ctx_store u_ctx_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ctx_req),
    .rdata_o (ctx_rdata),
    .busy_o  (ctx_busy)
  );

  assign in_if.ready = (state_q == lcgm_pkg::ST_IDLE);
  assign in_fire     = in_if.valid & in_if.ready;
  assign out_fire    = out_valid_q & out_if.ready;
  assign out_free    = ~out_valid_q | out_if.ready;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quant_q <= lcgm_pkg::QuantW'(lcgm_pkg::QuantReset);
    end else if (cfg_we_i) begin
      quant_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    med_hi   = (a_q >= b_q) ? a_q : b_q;
    med_lo   = (a_q >= b_q) ? b_q : a_q;
    med_grad = {1'b0, a_q} + {1'b0, b_q} - {1'b0, c_q};
    if (c_q >= med_hi) begin
      med_p = med_lo;
    end else if (c_q <= med_lo) begin
      med_p = med_hi;
    end else begin
      med_p = med_grad[PixW-1:0];
    end
  end

  always_comb begin
    ad_a = (a_q >= p_q) ? (a_q - p_q) : (p_q - a_q);
    ad_b = (b_q >= p_q) ? (b_q - p_q) : (p_q - b_q);
    ad_c = (c_q >= p_q) ? (c_q - p_q) : (p_q - c_q);
    act  = lcgm_pkg::ActW'(ad_a) + lcgm_pkg::ActW'(ad_b) + lcgm_pkg::ActW'(ad_c);
    tex  = {c_q > p_q, b_q > p_q, a_q > p_q};
  end

  // clamp the quantiser bit count, then drop the low activity bits
  always_comb begin
    s_clamp  = ({1'b0, quant_q} > 4'(lcgm_pkg::MaxQuantBits)) ?
               4'(lcgm_pkg::MaxQuantBits) : {1'b0, quant_q};
    act_sh   = 4'(lcgm_pkg::ActBits) - s_clamp;
    idx_next = {7'(act_q >> act_sh), tex};
  end

  assign search_done = (k_q == lcgm_pkg::KW'(lcgm_pkg::KLimit)) ||
                       (shift_q >= ShiftW'(sum_q));

  always_comb begin
    mapped       = {mag_q, neg_q};
    upd_sum_base = sum_q;
    upd_cnt_base = count_q;
    if (count_q == CountW'(lcgm_pkg::CountLimit)) begin
      upd_sum_base = sum_q >> 1;
      upd_cnt_base = count_q >> 1;
    end
    upd_sum_wide    = {1'b0, upd_sum_base} + (SumW + 1)'(mag_q);
    upd_entry.sum   = upd_sum_wide[SumW] ? '1 : upd_sum_wide[SumW-1:0];
    upd_entry.count = (&upd_cnt_base) ? upd_cnt_base : upd_cnt_base + 1'b1;
  end

  assign do_update = (state_q == lcgm_pkg::ST_UPDATE) && out_free;

  // sequencer
  always_comb begin
    state_d       = state_q;
    ctx_req.rd    = 1'b0;
    ctx_req.wr    = 1'b0;
    ctx_req.addr  = idx_q;
    ctx_req.wdata = upd_entry;
    case (state_q)
      lcgm_pkg::ST_CLEAR: begin
        if (!ctx_busy) begin
          state_d = lcgm_pkg::ST_IDLE;
        end
      end
      lcgm_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = lcgm_pkg::ST_PRED;
        end
      end
      lcgm_pkg::ST_PRED:   state_d = lcgm_pkg::ST_ACT;
      lcgm_pkg::ST_ACT:    state_d = lcgm_pkg::ST_READ;
      lcgm_pkg::ST_READ: begin
        // read at the fresh index; idx_q takes it at the same edge
        ctx_req.rd   = 1'b1;
        ctx_req.addr = idx_next;
        state_d      = lcgm_pkg::ST_LOAD;
      end
      lcgm_pkg::ST_LOAD:   state_d = lcgm_pkg::ST_SEARCH;
      lcgm_pkg::ST_SEARCH: begin
        if (search_done) begin
          state_d = lcgm_pkg::ST_UPDATE;
        end
      end
      lcgm_pkg::ST_UPDATE: begin
        if (out_free) begin
          ctx_req.wr = 1'b1;
          state_d    = lcgm_pkg::ST_IDLE;
        end
      end
      default: state_d = lcgm_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcgm_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q <= in_if.pixel_value;
      a_q <= in_if.left_neighbor;
      b_q <= in_if.upper_neighbor;
      c_q <= in_if.corner_neighbor;
    end
    if (state_q == lcgm_pkg::ST_PRED) begin
      p_q   <= med_p;
      neg_q <= x_q < med_p;
      mag_q <= (x_q < med_p) ? (med_p - x_q) : (x_q - med_p);
    end
    if (state_q == lcgm_pkg::ST_ACT) begin
      act_q <= act;
    end
    if (state_q == lcgm_pkg::ST_READ) begin
      idx_q <= idx_next;
    end
    if (state_q == lcgm_pkg::ST_LOAD) begin
      sum_q   <= ctx_rdata.sum;
      count_q <= ctx_rdata.count;
      shift_q <= ShiftW'(ctx_rdata.count);
      k_q     <= '0;
    end
    // advance the shift-and-compare one step per cycle
    if ((state_q == lcgm_pkg::ST_SEARCH) && !search_done) begin
      shift_q <= shift_q << 1;
      k_q     <= k_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_update) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_update) begin
      out_pred_q <= p_q;
      out_idx_q  <= idx_q;
      out_k_q    <= k_q;
      out_map_q  <= mapped;
      out_bin_q  <= mapped & ~({MapW{1'b1}} << k_q);
      out_una_q  <= {1'b0, mapped >> k_q} + 1'b1;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.prediction    = out_pred_q;
  assign out_if.context_index = out_idx_q;
  assign out_if.rice_k        = out_k_q;
  assign out_if.mapped_error  = out_map_q;
  assign out_if.binary_part   = out_bin_q;
  assign out_if.unary_length  = out_una_q;

endmodule

`default_nettype wire
